// ===== rtl/core/bls12_381_scalar_mont_reduce_sub_top_defines.svh =====
// Assertion macros for the scalar field reduce/subtract unit.
`ifndef BLS12_381_SCALAR_MONT_REDUCE_SUB_TOP_DEFINES_SVH
`define BLS12_381_SCALAR_MONT_REDUCE_SUB_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BMR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BMR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bmr_pkg.sv =====
// Shared constants and types for the scalar field reduce/subtract unit.
`default_nettype none
package bmr_pkg;

    localparam int LIMB_W = 64;
    localparam int HALF_W = 32;
    localparam int NUM_IN_LIMBS = 8;
    localparam int NUM_OUT_LIMBS = 4;
    localparam int ACC_W = LIMB_W * NUM_IN_LIMBS;
    localparam int FE_W = LIMB_W * NUM_OUT_LIMBS;
    localparam int NUM_ROUNDS = 4;

    localparam logic FUNC_REDUCE = 1'b0;
    localparam logic FUNC_SUB = 1'b1;

    // field modulus q
    localparam logic [FE_W-1:0] Q_MOD =
        256'h73eda753299d7d483339d80809a1d80553bda402fffe5bfeffffffff00000001;

    typedef struct packed {
        logic              valid;
        logic              func;
        logic [ACC_W-1:0]  acc;
    } bmr_beat_t;

endpackage
`default_nettype wire

// ===== rtl/core/bmr_in_if.sv =====
// Input channel: operation code and eight 64-bit limbs.
`default_nettype none
interface bmr_in_if import bmr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              func;
    logic [LIMB_W-1:0] in_w0;
    logic [LIMB_W-1:0] in_w1;
    logic [LIMB_W-1:0] in_w2;
    logic [LIMB_W-1:0] in_w3;
    logic [LIMB_W-1:0] in_w4;
    logic [LIMB_W-1:0] in_w5;
    logic [LIMB_W-1:0] in_w6;
    logic [LIMB_W-1:0] in_w7;

    modport source (output valid, func, in_w0, in_w1, in_w2, in_w3,
                    in_w4, in_w5, in_w6, in_w7, input ready);
    modport sink (input valid, func, in_w0, in_w1, in_w2, in_w3,
                  in_w4, in_w5, in_w6, in_w7, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bmr_out_if.sv =====
// Output channel: four 64-bit result limbs.
`default_nettype none
interface bmr_out_if import bmr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [LIMB_W-1:0] out_w0;
    logic [LIMB_W-1:0] out_w1;
    logic [LIMB_W-1:0] out_w2;
    logic [LIMB_W-1:0] out_w3;

    modport source (output valid, out_w0, out_w1, out_w2, out_w3, input ready);
    modport sink (input valid, out_w0, out_w1, out_w2, out_w3, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bls12_381_scalar_mont_reduce_sub_top.sv =====
// BLS12-381 scalar field unit: Montgomery reduction of a 512-bit value (func 0) or
// modular subtraction of two 256-bit values (func 1). Fully pipelined: one beat is
// accepted every cycle unless the output stalls. The pipeline is made of
// four reduction rounds of five stages each (quotient digit, 32x32 partial products,
// two adder levels, accumulate) and two stages for the final subtract and correction
// by q. Subtract beats ride through the rounds unchanged. When the output register is
// held, the whole pipeline freezes and input ready drops in the same cycle.
`default_nettype none
`include "bls12_381_scalar_mont_reduce_sub_top_defines.svh"
module bls12_381_scalar_mont_reduce_sub_top import bmr_pkg::*; (
    input wire logic clk,
    input wire logic rst_n,
    bmr_in_if.sink   in_ch,
    bmr_out_if.source out_ch
);
    logic             en;
    bmr_beat_t        r_beat [NUM_ROUNDS+1];
    logic [1:0]       fv_reg;
    logic [FE_W:0]    diff_reg;
    logic [FE_W:0]    diff_next;
    logic [FE_W-1:0]  res_reg;
    logic [FE_W-1:0]  res_next;
    logic [FE_W-1:0]  x_op;
    logic [FE_W-1:0]  y_op;

    assign en = !fv_reg[1] || out_ch.ready;
    assign in_ch.ready = en;

    assign r_beat[0].valid = in_ch.valid;
    assign r_beat[0].func  = in_ch.func;
    assign r_beat[0].acc   = {in_ch.in_w7, in_ch.in_w6, in_ch.in_w5, in_ch.in_w4,
                              in_ch.in_w3, in_ch.in_w2, in_ch.in_w1, in_ch.in_w0};

    for (genvar g = 0; g < NUM_ROUNDS; g++)
    begin : g_round
        bmr_round #(.ROUND(g)) u_round (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .beat_in  (r_beat[g]),
            .beat_out (r_beat[g+1])
        );
    end

    always_comb
    begin
        if (r_beat[NUM_ROUNDS].func == FUNC_SUB)
        begin
            x_op = r_beat[NUM_ROUNDS].acc[FE_W-1:0];
            y_op = r_beat[NUM_ROUNDS].acc[ACC_W-1:FE_W];
        end
        else
        begin
            x_op = r_beat[NUM_ROUNDS].acc[ACC_W-1:FE_W];
            y_op = Q_MOD;
        end
        diff_next = {1'b0, x_op} - {1'b0, y_op};
    end

    assign res_next = diff_reg[FE_W-1:0] + (diff_reg[FE_W] ? Q_MOD : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
        end
        else if (en)
        begin
            fv_reg <= {fv_reg[0], r_beat[NUM_ROUNDS].valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= diff_next;
            res_reg  <= res_next;
        end
    end

    assign out_ch.valid  = fv_reg[1];
    assign out_ch.out_w0 = res_reg[LIMB_W*0 +: LIMB_W];
    assign out_ch.out_w1 = res_reg[LIMB_W*1 +: LIMB_W];
    assign out_ch.out_w2 = res_reg[LIMB_W*2 +: LIMB_W];
    assign out_ch.out_w3 = res_reg[LIMB_W*3 +: LIMB_W];

    // each reduce round clears its own low limb
    `BMR_ASSERT_IMPL(a_round0_low_zero, r_beat[1].valid && !r_beat[1].func,
        r_beat[1].acc[LIMB_W-1:0] == '0, "round 0 left a nonzero low limb")
    `BMR_ASSERT_IMPL(a_rounds_low_zero, r_beat[NUM_ROUNDS].valid && !r_beat[NUM_ROUNDS].func,
        r_beat[NUM_ROUNDS].acc[FE_W-1:0] == '0, "reduction left nonzero low half")
    `BMR_ASSERT_IMPL(a_stall_blocks_in, out_ch.valid && !out_ch.ready,
        !in_ch.ready, "input taken while output stalled")
    `BMR_ASSERT_NEXT(a_stall_freezes, out_ch.valid && !out_ch.ready,
        $stable(r_beat[NUM_ROUNDS].acc), "pipeline moved during stall")

endmodule
`default_nettype wire

// ===== rtl/core/bmr_round.sv =====
// One Montgomery reduction round as a five-stage pipeline.
`default_nettype none
module bmr_round import bmr_pkg::*; #(
    parameter int ROUND = 0
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    input  wire bmr_beat_t beat_in,
    output bmr_beat_t      beat_out
);
    localparam int SHIFT = ROUND * LIMB_W;
    localparam int NUM_Q_HALVES = FE_W / HALF_W;
    localparam int ROW_W = FE_W + HALF_W;
    localparam int PROD_W = FE_W + LIMB_W;

    logic [4:0]        v_reg;
    logic [4:0]        f_reg;
    logic [ACC_W-1:0]  acc_reg [5];
    logic [LIMB_W-1:0] m_reg;
    logic [LIMB_W-1:0] m_next;
    logic [LIMB_W-1:0] t_limb;
    logic [LIMB_W-1:0] pp_reg  [2][NUM_Q_HALVES];
    logic [LIMB_W-1:0] pp_next [2][NUM_Q_HALVES];
    logic [ROW_W-1:0]  row_reg  [2];
    logic [ROW_W-1:0]  row_next [2];
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [ACC_W-1:0]  acc_next;

    // -q^-1 mod 2^64 = 2^64 - 2^32 - 1, so m = -(t + t<<32)
    always_comb
    begin
        t_limb = beat_in.acc[SHIFT +: LIMB_W];
        if (beat_in.func == FUNC_SUB)
        begin
            m_next = '0;
        end
        else
        begin
            m_next = LIMB_W'(0) - (t_limb + {t_limb[HALF_W-1:0], {HALF_W{1'b0}}});
        end
    end

    always_comb
    begin
        for (int h = 0; h < 2; h++)
        begin
            for (int k = 0; k < NUM_Q_HALVES; k++)
            begin
                pp_next[h][k] = LIMB_W'(m_reg[HALF_W*h +: HALF_W])
                              * LIMB_W'(Q_MOD[HALF_W*k +: HALF_W]);
            end
        end
    end

    // even-indexed partials tile without overlap, odd ones too, 32 bits up
    always_comb
    begin
        logic [FE_W-1:0] ev;
        logic [FE_W-1:0] od;
        for (int h = 0; h < 2; h++)
        begin
            for (int j = 0; j < NUM_Q_HALVES/2; j++)
            begin
                ev[LIMB_W*j +: LIMB_W] = pp_reg[h][2*j];
                od[LIMB_W*j +: LIMB_W] = pp_reg[h][2*j+1];
            end
            row_next[h] = {{HALF_W{1'b0}}, ev} + {od, {HALF_W{1'b0}}};
        end
    end

    assign prod_next = {{HALF_W{1'b0}}, row_reg[0]} + {row_reg[1], {HALF_W{1'b0}}};
    assign acc_next = acc_reg[3] + (ACC_W'(prod_reg) << SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[3:0], beat_in.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_reg      <= {f_reg[3:0], beat_in.func};
            acc_reg[0] <= beat_in.acc;
            acc_reg[1] <= acc_reg[0];
            acc_reg[2] <= acc_reg[1];
            acc_reg[3] <= acc_reg[2];
            acc_reg[4] <= acc_next;
            m_reg      <= m_next;
            pp_reg     <= pp_next;
            row_reg    <= row_next;
            prod_reg   <= prod_next;
        end
    end

    assign beat_out.valid = v_reg[4];
    assign beat_out.func  = f_reg[4];
    assign beat_out.acc   = acc_reg[4];

endmodule
`default_nettype wire
